[hw/rtl/bfsa_pkg.sv]
// ----------------------------------------------------------------------------
// bfsa_pkg
// Shared types, constants and helpers of the best-fit segment allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bfsa_pkg;

    // heap geometry
    localparam int GRANULES   = 1024;
    localparam int IDX_W      = $clog2(GRANULES);
    localparam int LEN_W      = IDX_W + 1;
    localparam int GRAN_SH    = 4;
    localparam int PAGE_SH    = 12;
    localparam int HB_W       = 14;
    localparam int REQ_W      = 15;
    localparam logic [HB_W-1:0] HEAP_RESET = 14'd8192;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_NOFIT  = 2'd1,
        ST_BADREL = 2'd2
    } t_status;

    typedef struct packed {
        logic                 operation;
        logic [REQ_W-1:0]     request_bytes;
        logic [HB_W-1:0]      release_offset;
    } t_req;

    typedef struct packed {
        logic [1:0]           status;
        logic [HB_W-1:0]      block_offset;
        logic [REQ_W-1:0]     block_bytes;
    } t_rsp;

    // one segment table entry
    typedef struct packed {
        logic                 valid;
        logic                 free;
        logic [LEN_W-1:0]     len;
        logic [IDX_W-1:0]     prev;
    } t_seg;

    // datapath actions issued by the controller
    typedef enum logic [4:0] {
        DP_NOP,
        DP_FMT_STEP,
        DP_LOAD,
        DP_SCAN_STEP,
        DP_A_DECIDE,
        DP_W_START,
        DP_A_W_REST,
        DP_RD_AFT,
        DP_W_AFT,
        DP_R_RD_G,
        DP_R_CHK_G,
        DP_R_RD_N,
        DP_R_MERGE,
        DP_R_W_NEXT,
        DP_R_W_G,
        DP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_cmd;

    typedef struct packed {
        logic cfg_fire;
        logic fmt_last;
        logic scan_last;
        logic found;
        logic split;
        logic aft_in;
        logic bad_off;
        logic bad_g;
        logic next_free;
        logic prev_free;
        logic is_release;
        logic out_busy;
    } t_sts;

    typedef enum logic [4:0] {
        S_FMT,
        S_IDLE,
        S_A_SCAN,
        S_A_LAST,
        S_A_DECIDE,
        S_W_START,
        S_A_W_REST,
        S_RD_AFT,
        S_W_AFT,
        S_R_RD_G,
        S_R_CHK_G,
        S_R_RD_N,
        S_R_MERGE,
        S_R_W_NEXT,
        S_R_W_G,
        S_DONE
    } t_state;

    // padded heap size in granules, rounded to pages, saturated
    function automatic logic [LEN_W-1:0] heap_end(input logic [HB_W-1:0] hb);
        logic [HB_W+1:0] padded;
        logic [HB_W+1-PAGE_SH:0] pages;
        logic [LEN_W+HB_W-PAGE_SH:0] gran;
        padded = {2'b00, hb} + (HB_W+2)'(2**GRAN_SH) + (HB_W+2)'(2**PAGE_SH - 1);
        pages  = padded[HB_W+1:PAGE_SH];
        gran   = {(LEN_W+HB_W-PAGE_SH+1-(HB_W+2-PAGE_SH)-(PAGE_SH-GRAN_SH))'(0),
                  pages, (PAGE_SH-GRAN_SH)'(0)};
        if (gran > (LEN_W+HB_W-PAGE_SH+1)'(GRANULES)) begin
            return LEN_W'(GRANULES);
        end
        return gran[LEN_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/bfsa_ctrl.sv]
// ----------------------------------------------------------------------------
// bfsa_ctrl
// Controller state machine: sequences format sweep, best-fit scan, split
// writes and release merge over the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsa_ctrl
    import bfsa_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    input  wire logic i_req_op,
    output logic      o_req_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FMT;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_FMT:      if (i_sts.fmt_last) n_state = S_IDLE;
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = (i_req_op == OP_RELEASE) ? S_R_RD_G : S_A_SCAN;
                end
            end
            S_A_SCAN:   if (i_sts.scan_last) n_state = S_A_LAST;
            S_A_LAST:   n_state = S_A_DECIDE;
            S_A_DECIDE: n_state = i_sts.found ? S_W_START : S_DONE;
            S_W_START: begin
                if (i_sts.is_release) begin
                    n_state = i_sts.aft_in ? S_RD_AFT : S_DONE;
                end else begin
                    n_state = i_sts.split ? S_A_W_REST : S_DONE;
                end
            end
            S_A_W_REST: n_state = i_sts.aft_in ? S_RD_AFT : S_DONE;
            S_RD_AFT:   n_state = S_W_AFT;
            S_W_AFT:    n_state = S_DONE;
            S_R_RD_G:   n_state = i_sts.bad_off ? S_DONE : S_R_CHK_G;
            S_R_CHK_G:  n_state = i_sts.bad_g ? S_DONE : S_R_RD_N;
            S_R_RD_N:   n_state = S_R_MERGE;
            S_R_MERGE: begin
                if (i_sts.next_free) begin
                    n_state = S_R_W_NEXT;
                end else if (i_sts.prev_free) begin
                    n_state = S_R_W_G;
                end else begin
                    n_state = S_W_START;
                end
            end
            S_R_W_NEXT: n_state = i_sts.prev_free ? S_R_W_G : S_W_START;
            S_R_W_G:    n_state = S_W_START;
            S_DONE:     if (!i_sts.out_busy) n_state = S_IDLE;
            default:    n_state = S_FMT;
        endcase
        // a heap size write restarts formatting
        if (i_sts.cfg_fire) begin
            n_state = S_FMT;
        end
    end

    // outputs
    always_comb begin
        o_cmd.op    = DP_NOP;
        o_req_ready = 1'b0;
        case (r_state)
            S_FMT:      o_cmd.op = DP_FMT_STEP;
            S_IDLE: begin
                // a size write in the same cycle holds the request off
                o_req_ready = !i_sts.cfg_fire;
                if (i_req_valid && !i_sts.cfg_fire) o_cmd.op = DP_LOAD;
            end
            S_A_SCAN:   o_cmd.op = DP_SCAN_STEP;
            S_A_LAST:   o_cmd.op = DP_NOP;
            S_A_DECIDE: o_cmd.op = DP_A_DECIDE;
            S_W_START:  o_cmd.op = DP_W_START;
            S_A_W_REST: o_cmd.op = DP_A_W_REST;
            S_RD_AFT:   o_cmd.op = DP_RD_AFT;
            S_W_AFT:    o_cmd.op = DP_W_AFT;
            S_R_RD_G:   o_cmd.op = DP_R_RD_G;
            S_R_CHK_G:  o_cmd.op = DP_R_CHK_G;
            S_R_RD_N:   o_cmd.op = DP_R_RD_N;
            S_R_MERGE:  o_cmd.op = DP_R_MERGE;
            S_R_W_NEXT: o_cmd.op = DP_R_W_NEXT;
            S_R_W_G:    o_cmd.op = DP_R_W_G;
            S_DONE:     if (!i_sts.out_busy) o_cmd.op = DP_EMIT;
            default:    o_cmd.op = DP_NOP;
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/bfsa_dp.sv]
// ----------------------------------------------------------------------------
// bfsa_dp
// Datapath: segment table memory, heap end register, scan compare,
// split and merge arithmetic, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsa_dp
    import bfsa_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_cmd            i_cmd,
    output t_sts                 o_sts,
    input  wire t_req            i_req,
    input  wire logic            i_cfg_valid,
    input  wire logic [HB_W-1:0] i_cfg_heap_bytes,
    output logic                 o_rsp_valid,
    input  wire logic            i_rsp_ready,
    output t_rsp                 o_rsp
);

    t_seg mem [0:GRANULES-1];

    logic [LEN_W-1:0] r_end;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_ridx;
    logic             r_pend;
    logic             r_op;
    logic [LEN_W-1:0] r_want;
    logic [HB_W-1:0]  r_off;
    t_seg             r_rdata;
    logic             r_found;
    logic [IDX_W-1:0] r_best_idx;
    t_seg             r_best;
    t_seg             r_cur;
    t_seg             r_prv;
    logic [LEN_W-1:0] r_next;
    t_seg             r_new;
    t_seg             r_rest;
    logic [LEN_W-1:0] r_aft;
    logic [IDX_W-1:0] r_aft_prev;
    t_status          r_status;
    logic [IDX_W-1:0] r_start;
    logic [LEN_W-1:0] r_mlen;
    logic             r_ovalid;
    t_rsp             r_rsp;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_seg             wr_data;
    logic [IDX_W-1:0] g_idx;
    logic             cand;
    logic             pf_c;
    logic             nf_c;
    logic [LEN_W-1:0] mlen_c;
    logic [IDX_W-1:0] mstart_c;
    logic [REQ_W:0]   want_sum;
    logic [LEN_W-1:0] want_c;
    logic             emit;

    assign g_idx    = r_off[HB_W-1:GRAN_SH];
    assign emit     = (i_cmd.op == DP_EMIT);
    assign want_sum = {1'b0, i_req.request_bytes} + (REQ_W+1)'(2**GRAN_SH - 1);
    // oversized requests saturate above any segment length
    assign want_c   = want_sum[REQ_W] ? '1
                    : (want_sum[REQ_W-1:GRAN_SH] == '0) ? LEN_W'(1)
                                                         : want_sum[GRAN_SH+LEN_W-1:GRAN_SH];

    // scan candidate: free valid segment that fits and beats the best so far
    assign cand = r_pend && r_rdata.valid && r_rdata.free && (r_rdata.len >= r_want)
               && (!r_found || (r_rdata.len < r_best.len));

    // release merge terms, next entry arrives in r_rdata
    assign pf_c     = ({1'b0, r_cur.prev} < r_end) && r_prv.valid && r_prv.free;
    assign nf_c     = (r_next < r_end) && r_rdata.valid && r_rdata.free;
    assign mstart_c = pf_c ? r_cur.prev : g_idx;
    assign mlen_c   = r_cur.len + (nf_c ? r_rdata.len : '0) + (pf_c ? r_prv.len : '0);

    // memory address and data selection
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_idx;
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = '0;
        case (i_cmd.op)
            DP_FMT_STEP: begin
                wr_en = 1'b1;
                if (r_idx == IDX_W'(0)) begin
                    wr_data = '{valid: 1'b1, free: 1'b0, len: LEN_W'(1), prev: '0};
                end else if (r_idx == IDX_W'(1) && r_end > LEN_W'(1)) begin
                    wr_data = '{valid: 1'b1, free: 1'b1, len: r_end - LEN_W'(1), prev: '0};
                end
            end
            DP_SCAN_STEP: rd_en = 1'b1;
            DP_W_START: begin
                wr_en   = 1'b1;
                wr_addr = r_start;
                wr_data = r_new;
            end
            DP_A_W_REST: begin
                wr_en   = 1'b1;
                wr_addr = r_aft_prev;
                wr_data = r_rest;
            end
            DP_RD_AFT: begin
                rd_en   = 1'b1;
                rd_addr = r_aft[IDX_W-1:0];
            end
            DP_W_AFT: begin
                wr_en        = 1'b1;
                wr_addr      = r_aft[IDX_W-1:0];
                wr_data      = r_rdata;
                wr_data.prev = r_aft_prev;
            end
            DP_R_RD_G: begin
                rd_en   = 1'b1;
                rd_addr = g_idx;
            end
            DP_R_CHK_G: begin
                rd_en   = 1'b1;
                rd_addr = r_rdata.prev;
            end
            DP_R_RD_N: begin
                rd_en   = 1'b1;
                rd_addr = g_idx + r_cur.len[IDX_W-1:0];
            end
            DP_R_W_NEXT: begin
                wr_en   = 1'b1;
                wr_addr = r_next[IDX_W-1:0];
                wr_data = '0;
            end
            DP_R_W_G: begin
                wr_en   = 1'b1;
                wr_addr = g_idx;
                wr_data = '0;
            end
            default: rd_en = 1'b0;
        endcase
    end

    // segment table
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // heap end and sweep / scan index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end  <= heap_end(HEAP_RESET);
            r_idx  <= '0;
            r_pend <= 1'b0;
        end else begin
            r_pend <= (i_cmd.op == DP_SCAN_STEP);
            if (i_cfg_valid) begin
                r_end <= heap_end(i_cfg_heap_bytes);
                r_idx <= '0;
            end else if (i_cmd.op == DP_LOAD) begin
                r_idx <= '0;
            end else if (i_cmd.op == DP_FMT_STEP || i_cmd.op == DP_SCAN_STEP) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    // best-fit tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.op == DP_LOAD) begin
            r_found <= 1'b0;
        end else if (cand) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_SCAN_STEP) begin
            r_ridx <= r_idx;
        end
        if (cand) begin
            r_best_idx <= r_ridx;
            r_best     <= r_rdata;
        end
    end

    // request latch and operation arithmetic
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: begin
                r_op   <= i_req.operation;
                r_want <= want_c;
                r_off  <= i_req.release_offset;
            end
            DP_A_DECIDE: begin
                if (r_found) begin
                    r_status <= ST_DONE;
                    r_start  <= r_best_idx;
                    r_mlen   <= r_want;
                end else begin
                    r_status <= ST_NOFIT;
                    r_start  <= '0;
                    r_mlen   <= '0;
                end
                r_new      <= '{valid: 1'b1, free: 1'b0,
                                len: (r_best.len > r_want) ? r_want : r_best.len,
                                prev: r_best.prev};
                r_rest     <= '{valid: 1'b1, free: 1'b1, len: r_best.len - r_want,
                                prev: r_best_idx};
                r_aft      <= {1'b0, r_best_idx} + r_best.len;
                r_aft_prev <= r_best_idx + r_want[IDX_W-1:0];
            end
            DP_R_RD_G: begin
                r_status <= ST_BADREL;
                r_start  <= '0;
                r_mlen   <= '0;
            end
            DP_R_CHK_G: r_cur <= r_rdata;
            DP_R_RD_N: begin
                r_prv  <= r_rdata;
                r_next <= {1'b0, g_idx} + r_cur.len;
            end
            DP_R_MERGE: begin
                r_status   <= ST_DONE;
                r_start    <= mstart_c;
                r_mlen     <= mlen_c;
                r_new      <= '{valid: 1'b1, free: 1'b1, len: mlen_c,
                                prev: pf_c ? r_prv.prev : r_cur.prev};
                r_aft      <= {1'b0, mstart_c} + mlen_c;
                r_aft_prev <= mstart_c;
            end
            default: r_op <= r_op;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit) begin
            r_ovalid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_rsp.status       <= r_status;
            r_rsp.block_offset <= {r_start, GRAN_SH'(0)};
            r_rsp.block_bytes  <= {r_mlen, GRAN_SH'(0)};
        end
    end

    assign o_rsp_valid = r_ovalid;
    assign o_rsp       = r_rsp;

    // status to controller, merge flags stay stable through the merge writes
    always_comb begin
        o_sts.cfg_fire   = i_cfg_valid;
        o_sts.fmt_last   = (r_idx == IDX_W'(GRANULES - 1));
        o_sts.scan_last  = ({1'b0, r_idx} == r_end - LEN_W'(1));
        o_sts.found      = r_found;
        o_sts.split      = (r_rest.len != '0);
        o_sts.aft_in     = (r_aft < r_end);
        o_sts.bad_off    = (r_off[GRAN_SH-1:0] != '0) || (g_idx == '0)
                        || ({1'b0, g_idx} >= r_end);
        o_sts.bad_g      = !r_rdata.valid || r_rdata.free;
        o_sts.next_free  = nf_c;
        o_sts.prev_free  = pf_c;
        o_sts.is_release = (r_op == OP_RELEASE);
        o_sts.out_busy   = r_ovalid && !i_rsp_ready;
    end

    // checks
    a_found_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (r_best.len >= r_want && r_best.valid && r_best.free))
        else $error("best segment does not fit");

    a_ok_not_sentinel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && r_status == ST_DONE) |-> (r_start != '0 && r_mlen != '0))
        else $error("successful result names the sentinel or is empty");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && r_status != ST_DONE) |=> (o_rsp.block_offset == '0
                                          && o_rsp.block_bytes == '0))
        else $error("failed result carries nonzero fields");

    a_end_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cfg_valid) |-> (r_end != '0 && r_end <= LEN_W'(GRANULES) && r_idx == '0))
        else $error("heap end out of range after size write");

endmodule

`default_nettype wire

[hw/rtl/best_fit_segment_allocator_core.sv]
// ----------------------------------------------------------------------------
// best_fit_segment_allocator_core
// Best-fit heap allocator with split and coalescing over a segment table.
// ----------------------------------------------------------------------------
// usage
// request channel (i_req_valid / o_req_ready, i_req): allocate or release.
// response channel (o_rsp_valid / i_rsp_ready, o_rsp): one response per
// request, status plus block offset and length in bytes.
// config channel (i_cfg_valid / o_cfg_ready, i_cfg_heap_bytes): sets the heap
// size and reformats the table; write only while the block is idle.
// one request at a time through a single-port segment table of 1024 entries.
// allocate: best-fit scan reads one entry a cycle up to the heap end, then
// decides; a fit writes the block, a split rest and the next segment link.
// release: table reads and writes that merge with free neighbours; a
// rejected offset ends the release before the merge.
// reset and every heap size write run a format sweep of all 1024 entries,
// one entry a cycle, during which o_req_ready is low.
// the response sits in an output register; a new request is taken while it
// waits, and a finished request holds until the response register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module best_fit_segment_allocator_core
    import bfsa_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_req_valid,
    output logic                 o_req_ready,
    input  wire t_req            i_req,
    output logic                 o_rsp_valid,
    input  wire logic            i_rsp_ready,
    output t_rsp                 o_rsp,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [HB_W-1:0] i_cfg_heap_bytes
);

    t_cmd cmd;
    t_sts sts;

    // size writes are always taken
    assign o_cfg_ready = 1'b1;

    bfsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req_op    (i_req.operation),
        .o_req_ready (o_req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bfsa_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_req            (i_req),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_heap_bytes (i_cfg_heap_bytes),
        .o_rsp_valid      (o_rsp_valid),
        .i_rsp_ready      (i_rsp_ready),
        .o_rsp            (o_rsp)
    );

endmodule

`default_nettype wire
